### hdl/ut2c_pkg.sv
// Package: shared types, constants and calendar helpers for the time-to-calendar converter
`timescale 1ns / 1ps

package ut2c_pkg;

    // Field widths
    localparam int SECS_W  = 32;
    localparam int DAYS_W  = 16;
    localparam int TOD_W   = 17;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Time constants
    localparam logic [TOD_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;

    // Reciprocals for division by constants: x / (d << s) = ((x >> s) * R) >> K,
    // exact over the input range of each field
    localparam int                     DAY_PRE_SHIFT    = 7;
    localparam int                     DAY_RECIP_W      = 26;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP        = 26'd50903317;
    localparam int                     DAY_RECIP_SHIFT  = 35;
    localparam int                     HOUR_PRE_SHIFT   = 4;
    localparam int                     HOUR_RECIP_W     = 14;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP      = 14'd9321;
    localparam int                     HOUR_RECIP_SHIFT = 21;
    localparam int                     MIN_PRE_SHIFT    = 2;
    localparam int                     MIN_RECIP_W      = 11;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP        = 11'd1093;
    localparam int                     MIN_RECIP_SHIFT  = 14;
    localparam int                     WDAY_RECIP_W     = 17;
    localparam logic [WDAY_RECIP_W-1:0] WDAY_RECIP      = 17'd74899;
    localparam int                     WDAY_RECIP_SHIFT = 19;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  FIRST_YEAR      = 12'd1970;
    localparam logic [YEAR_W-1:0]  NO_LEAP_CENTURY = 12'd2100;
    localparam logic [DAYS_W-1:0]  LEAP_DAY_IDX    = 16'd59;
    localparam logic [8:0]         DAYS_NORMAL     = 9'd365;
    localparam logic [8:0]         DAYS_LEAP       = 9'd366;
    localparam logic [MONTH_W-1:0] FEB_IDX         = 4'd1;
    localparam logic [MONTH_W-1:0] DEC_IDX         = 4'd11;
    localparam logic [DOM_W-1:0]   FEB_LEAP_DOM    = 5'd29;
    localparam logic [WDAY_W:0]    EPOCH_WDAY      = 4'd4;
    localparam logic [WDAY_W:0]    DAYS_PER_WEEK   = 4'd7;

    // Word handed from front to back: whole days and seconds within the day
    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } ut2c_entry_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_REM,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HOUR,
        BK_HREM,
        BK_MIN,
        BK_YEAR,
        BK_ADJ,
        BK_MONTH,
        BK_EMIT
    } back_state_t;

    // Leap test, valid over the reachable years 1970..2106 (only 2000 and 2100 are centuries)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != NO_LEAP_CENTURY);
    endfunction

    // Day index of the first day of each month in a non-leap year
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/ut2c_front.sv
// Front end: accepts a timestamp word and splits it into days and seconds of day
`timescale 1ns / 1ps

module ut2c_front
    import ut2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SECS_W-1:0] unix_seconds,
    output logic              push,
    output ut2c_entry_t       push_data,
    input  logic              full
);

    localparam int QIN_W   = SECS_W - DAY_PRE_SHIFT;
    localparam int QPROD_W = QIN_W + DAY_RECIP_W;
    localparam int BASE_W  = SECS_W + 1;

    front_state_t       st_reg, st_next;
    logic [SECS_W-1:0]  acc_reg, acc_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [TOD_W-1:0]   rem_reg, rem_next;
    logic [QPROD_W-1:0] day_prod;
    logic [BASE_W-1:0]  day_base;
    logic [SECS_W-1:0]  tod_full;

    // Hold state and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= FR_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        days_reg <= days_next;
        rem_reg  <= rem_next;
    end

    assign push_data.days = days_reg;
    assign push_data.tod  = rem_reg;

    // Days by reciprocal multiply, then seconds of day by multiply and subtract
    always_comb
    begin
        st_next   = st_reg;
        acc_next  = acc_reg;
        days_next = days_reg;
        rem_next  = rem_reg;
        push      = 1'b0;
        in_stall  = 1'b1;
        day_prod  = QPROD_W'(acc_reg[SECS_W-1:DAY_PRE_SHIFT]) * QPROD_W'(DAY_RECIP);
        day_base  = BASE_W'(days_reg) * BASE_W'(SECS_PER_DAY);
        tod_full  = acc_reg - day_base[SECS_W-1:0];
        unique case (st_reg)
            FR_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    acc_next = unix_seconds;
                    st_next  = FR_DIV;
                end
            end
            FR_DIV:
            begin
                days_next = day_prod[DAY_RECIP_SHIFT +: DAYS_W];
                st_next   = FR_REM;
            end
            FR_REM:
            begin
                rem_next = tod_full[TOD_W-1:0];
                st_next  = FR_PUSH;
            end
            FR_PUSH:
            begin
                // Hand the word over once the queue has room
                if (!full)
                begin
                    push    = 1'b1;
                    st_next = FR_IDLE;
                end
            end
            default:
            begin
                st_next = FR_IDLE;
            end
        endcase
    end

endmodule

### hdl/ut2c_fifo.sv
// Short register queue between the front end and the calendar back end
`timescale 1ns / 1ps

module ut2c_fifo
    import ut2c_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ut2c_entry_t                push_data,
    input  logic                       pop,
    output ut2c_entry_t                head,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    ut2c_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (lvl_reg == LVL_W'(DEPTH));
    assign empty   = (lvl_reg == '0);
    assign level   = lvl_reg;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        lvl_next    = lvl_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            lvl_next = lvl_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            lvl_next = lvl_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lvl_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            lvl_reg    <= lvl_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/ut2c_back.sv
// Back end: turns days and seconds of day into clock fields and a calendar date
`timescale 1ns / 1ps

module ut2c_back
    import ut2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  ut2c_entry_t        head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SEC_W-1:0]   second,
    output logic [MIN_W-1:0]   minute,
    output logic [HOUR_W-1:0]  hour,
    output logic [WDAY_W-1:0]  weekday,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day_of_month
);

    // Seconds within the hour fit in 12 bits
    localparam int HREM_W   = 12;
    localparam int HIN_W    = TOD_W - HOUR_PRE_SHIFT;
    localparam int HPROD_W  = HIN_W + HOUR_RECIP_W;
    localparam int MIN_IN_W = HREM_W - MIN_PRE_SHIFT;
    localparam int MPROD_W  = MIN_IN_W + MIN_RECIP_W;
    localparam int WPROD_W  = DAYS_W + WDAY_RECIP_W;
    localparam int WEEKS_W  = 13;

    back_state_t        st_reg, st_next;
    logic [DAYS_W-1:0]  days_reg, days_next;
    logic [TOD_W-1:0]   tod_reg, tod_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [WEEKS_W-1:0] weeks_reg, weeks_next;
    logic [WDAY_W-1:0]  wrem_reg, wrem_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] mon_reg, mon_next;
    logic [DOM_W-1:0]   dom_reg, dom_next;
    logic               out_valid_reg, out_valid_next;
    logic [SEC_W-1:0]   o_sec_reg, o_sec_next;
    logic [MIN_W-1:0]   o_min_reg, o_min_next;
    logic [HOUR_W-1:0]  o_hour_reg, o_hour_next;
    logic [WDAY_W-1:0]  o_wday_reg, o_wday_next;
    logic [YEAR_W-1:0]  o_year_reg, o_year_next;
    logic [MONTH_W-1:0] o_mon_reg, o_mon_next;
    logic [DOM_W-1:0]   o_dom_reg, o_dom_next;

    logic [HPROD_W-1:0] hour_prod;
    logic [MPROD_W-1:0] min_prod;
    logic [WPROD_W-1:0] wk_prod;
    logic [DAYS_W-1:0]  wsum;
    logic [DAYS_W-1:0]  wk_base;
    logic [TOD_W-1:0]   hour_base;
    logic [TOD_W-1:0]   sec_base;
    logic               leap;
    logic [8:0]         year_len;
    logic [8:0]         ms;

    assign out_valid    = out_valid_reg;
    assign second       = o_sec_reg;
    assign minute       = o_min_reg;
    assign hour         = o_hour_reg;
    assign weekday      = o_wday_reg;
    assign year         = o_year_reg;
    assign month        = o_mon_reg;
    assign day_of_month = o_dom_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working values and the result word
    always_ff @(posedge clk)
    begin
        days_reg   <= days_next;
        tod_reg    <= tod_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        weeks_reg  <= weeks_next;
        wrem_reg   <= wrem_next;
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        dom_reg    <= dom_next;
        o_sec_reg  <= o_sec_next;
        o_min_reg  <= o_min_next;
        o_hour_reg <= o_hour_next;
        o_wday_reg <= o_wday_next;
        o_year_reg <= o_year_next;
        o_mon_reg  <= o_mon_next;
        o_dom_reg  <= o_dom_next;
    end

    // Sequence: pop, hour and weekday, minute, year stepping, leap-day adjust, month search, emit
    always_comb
    begin
        st_next        = st_reg;
        days_next      = days_reg;
        tod_next       = tod_reg;
        hour_next      = hour_reg;
        min_next       = min_reg;
        weeks_next     = weeks_reg;
        wrem_next      = wrem_reg;
        year_next      = year_reg;
        mon_next       = mon_reg;
        dom_next       = dom_reg;
        o_sec_next     = o_sec_reg;
        o_min_next     = o_min_reg;
        o_hour_next    = o_hour_reg;
        o_wday_next    = o_wday_reg;
        o_year_next    = o_year_reg;
        o_mon_next     = o_mon_reg;
        o_dom_next     = o_dom_reg;
        pop            = 1'b0;
        // Drop the result word once it is taken
        out_valid_next = out_valid_reg && out_stall;

        // Quotients by reciprocal multiply, remainders by multiply and subtract
        wsum      = days_reg + DAYS_W'(EPOCH_WDAY);
        hour_prod = HPROD_W'(tod_reg[TOD_W-1:HOUR_PRE_SHIFT]) * HPROD_W'(HOUR_RECIP);
        min_prod  = MPROD_W'(tod_reg[HREM_W-1:MIN_PRE_SHIFT]) * MPROD_W'(MIN_RECIP);
        wk_prod   = WPROD_W'(wsum) * WPROD_W'(WDAY_RECIP);
        wk_base   = DAYS_W'(weeks_reg) * DAYS_W'(DAYS_PER_WEEK);
        hour_base = TOD_W'(hour_reg) * SECS_PER_HOUR;
        sec_base  = TOD_W'(min_reg) * SECS_PER_MIN;
        leap      = is_leap(year_reg);
        year_len  = leap ? DAYS_LEAP : DAYS_NORMAL;
        ms        = month_start(mon_reg);

        unique case (st_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    days_next = head.days;
                    tod_next  = head.tod;
                    year_next = FIRST_YEAR;
                    st_next   = BK_HOUR;
                end
            end
            BK_HOUR:
            begin
                // Hours of the day and whole weeks since the epoch shifted to Sunday
                hour_next  = hour_prod[HOUR_RECIP_SHIFT +: HOUR_W];
                weeks_next = wk_prod[WDAY_RECIP_SHIFT +: WEEKS_W];
                st_next    = BK_HREM;
            end
            BK_HREM:
            begin
                // Seconds within the hour and the weekday
                tod_next  = tod_reg - hour_base;
                wrem_next = WDAY_W'(wsum - wk_base);
                st_next   = BK_MIN;
            end
            BK_MIN:
            begin
                min_next = min_prod[MIN_RECIP_SHIFT +: MIN_W];
                st_next  = BK_YEAR;
            end
            BK_YEAR:
            begin
                // Take off one whole year per cycle
                if (days_reg >= DAYS_W'(year_len))
                begin
                    days_next = days_reg - DAYS_W'(year_len);
                    year_next = year_reg + 1'b1;
                end
                else
                begin
                    st_next = BK_ADJ;
                end
            end
            BK_ADJ:
            begin
                if (leap && days_reg == LEAP_DAY_IDX)
                begin
                    // February 29 skips the table
                    mon_next = FEB_IDX;
                    dom_next = FEB_LEAP_DOM;
                    st_next  = BK_EMIT;
                end
                else
                begin
                    if (leap && days_reg > LEAP_DAY_IDX)
                    begin
                        days_next = days_reg - 1'b1;
                    end
                    mon_next = DEC_IDX;
                    st_next  = BK_MONTH;
                end
            end
            BK_MONTH:
            begin
                // Step back from December until the month start is reached
                if (mon_reg != '0 && DAYS_W'(ms) > days_reg)
                begin
                    mon_next = mon_reg - 1'b1;
                end
                else
                begin
                    dom_next = DOM_W'(days_reg - DAYS_W'(ms)) + 1'b1;
                    st_next  = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                // Load the result word when the output slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    o_sec_next     = SEC_W'(tod_reg - sec_base);
                    o_min_next     = min_reg;
                    o_hour_next    = hour_reg;
                    o_wday_next    = wrem_reg;
                    o_year_next    = year_reg;
                    o_mon_next     = mon_reg + 1'b1;
                    o_dom_next     = dom_reg;
                    out_valid_next = 1'b1;
                    st_next        = BK_IDLE;
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

endmodule

### hdl/unix_time_to_calendar_top.sv
// Top level: seconds-since-epoch to UTC calendar converter with front, queue and back end
//
// Usage:
//   Input channel: in_valid / in_stall carry one 32-bit word, unix_seconds, the
//   count of seconds since 1970-01-01 00:00:00 UTC. A word is taken at a clock
//   edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry one result word per input word:
//   second, minute, hour, weekday (0 is Sunday), year, month and day_of_month.
//   Flow: the front end splits a word into days and seconds of day (multiply
//   by a reciprocal, then multiply and subtract) and hands it to the queue; it
//   takes no new word until that handoff is done, which waits while the queue
//   is full. The back end pops a word, works out hour, weekday and minute,
//   steps through the elapsed years (0 to 136) one at a time, adjusts for the
//   leap day, searches back for the month (skipped for February 29) and emits.
//   The year stepping sets the throughput of one word per back-end pass; the
//   queue lets the front end overlap it.
//   Reset: rst_n low clears the state machines, the queue and out_valid.
//   Stall: while out_stall is high the result word holds; the back end waits
//   with its next result, the queue fills, and then in_stall rises.
`timescale 1ns / 1ps

module unix_time_to_calendar_top
    import ut2c_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SECS_W-1:0]  unix_seconds,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SEC_W-1:0]   second,
    output logic [MIN_W-1:0]   minute,
    output logic [HOUR_W-1:0]  hour,
    output logic [WDAY_W-1:0]  weekday,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DOM_W-1:0]   day_of_month
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic             push;
    ut2c_entry_t      push_data;
    logic             full;
    logic             empty;
    logic             pop;
    ut2c_entry_t      head;
    logic [LVL_W-1:0] level;

    ut2c_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .unix_seconds (unix_seconds),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    ut2c_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty),
        .level     (level)
    );

    ut2c_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .second       (second),
        .minute       (minute),
        .hour         (hour),
        .weekday      (weekday),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    // Front end goes busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("front end not busy after accepting a word");

    // Queue level stays within its depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // Clock fields of a valid result are in range
    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24 && weekday < 3'd7))
        else $error("clock field out of range");

    // Date fields of a valid result are in range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
                       && month <= 4'd12 && day_of_month >= 5'd1))
        else $error("date field out of range");

endmodule
